>>> src/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;
  localparam int SumW = 36;
  localparam int CordW = 40;
  localparam logic signed [SumW-1:0] OneQ28 = SumW'(64'sd268435456);
  localparam logic signed [33:0] HalfTurn = 34'sd2147483648;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic [15:0] RadScale = 16'd51472;

  function automatic logic [29:0] atan_val(input int i);
    logic [29:0] t [32];
    t = '{30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
          30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
          30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
          30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
          30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0};
    return t[i & 31];
  endfunction
endpackage
`default_nettype wire

>>> src/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic #(
  parameter int CORDIC_STEPS = 16,
  parameter int TagW = 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [q2e_pkg::CordW-1:0] in_y,
  input  wire logic signed [q2e_pkg::CordW-1:0] in_x,
  input  wire logic [TagW-1:0] in_tag,
  output logic out_valid,
  output logic signed [33:0] out_z,
  output logic [TagW-1:0] out_tag
);
  import q2e_pkg::*;
  localparam int N = CORDIC_STEPS + 1;
  logic v [N];
  logic signed [CordW-1:0] xs [N];
  logic signed [CordW-1:0] ys [N];
  logic signed [33:0] zs [N];
  logic [TagW-1:0] tg [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      tg[0] <= in_tag;
      if (in_x == '0 && in_y == '0) begin
        xs[0] <= '0; ys[0] <= '0; zs[0] <= '0;
      end else if (in_x < 0) begin
        xs[0] <= -in_x; ys[0] <= -in_y;
        zs[0] <= (in_y >= 0) ? HalfTurn : -HalfTurn;
      end else begin
        xs[0] <= in_x; ys[0] <= in_y; zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [33:0] A = 34'(atan_val(i));
    logic signed [CordW-1:0] dx, dy;
    assign dx = xs[i] >>> i;
    assign dy = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        tg[i+1] <= tg[i];
        if (xs[i] == '0 && ys[i] == '0) begin
          xs[i+1] <= '0; ys[i+1] <= '0; zs[i+1] <= zs[i];
        end else if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + dy; ys[i+1] <= ys[i] - dx; zs[i+1] <= zs[i] + A;
        end else begin
          xs[i+1] <= xs[i] - dy; ys[i+1] <= ys[i] + dx; zs[i+1] <= zs[i] - A;
        end
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_z = zs[N-1];
  assign out_tag = tg[N-1];
endmodule
`default_nettype wire

>>> src/q2e_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module q2e_isqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [56:0] in_v,
  input  wire logic signed [q2e_pkg::CordW-1:0] in_s,
  input  wire logic in_clamp,
  output logic out_valid,
  output logic [28:0] out_root,
  output logic signed [q2e_pkg::CordW-1:0] out_s,
  output logic out_clamp
);
  import q2e_pkg::*;
  localparam int N = 29;
  logic v [N+1];
  logic [57:0] rem [N+1];
  logic [28:0] res [N+1];
  logic signed [CordW-1:0] s [N+1];
  logic c [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= 58'(in_v); res[0] <= '0; s[0] <= in_s; c[0] <= in_clamp;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_bit
    localparam int Sh = 2 * (N - 1 - i);
    logic [57:0] trial;
    assign trial = ({29'd0, res[i]} << (Sh + 2)) | (58'd1 << Sh);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        s[i+1] <= s[i]; c[i+1] <= c[i];
        if (rem[i] >= trial) begin
          rem[i+1] <= rem[i] - trial; res[i+1] <= {res[i][27:0], 1'b1};
        end else begin
          rem[i+1] <= rem[i]; res[i+1] <= {res[i][27:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_root = res[N];
  assign out_s = s[N];
  assign out_clamp = c[N];
endmodule
`default_nettype wire

>>> src/quaternion_to_euler.sv
`timescale 1ns / 1ps
// Pipeline: 3 product/sum stages + 30 square-root stages + CORDIC_STEPS+1
// CORDIC stages + 2 output stages; roll/yaw are delayed to match pitch.
// Throughput: one word per cycle; the whole pipeline freezes on output stall.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module quaternion_to_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic pitch_clamped
);
  import q2e_pkg::*;
  localparam int Dly = 30;
  logic en;
  logic fin_v;
  assign en = !(fin_v && out_stall);
  assign in_stall = !en;

  logic v1, v2, v3;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic signed [SumW-1:0] sinr, cosr, sinp, siny, cosy;
  logic signed [29:0] sinp_lo;
  logic [56:0] sq_rem;
  logic signed [59:0] sq;
  logic clamp3;
  logic signed [CordW-1:0] sinp3;

  // below the clamp threshold the sine fits in 30 signed bits
  assign sinp_lo = sinp[29:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
    end
    if (en) begin
      p_wx <= quat_w * quat_x; p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x; p_yy <= quat_y * quat_y;
      p_wy <= quat_w * quat_y; p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z; p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
      sinr <= 36'(p_wx + 36'sd0 + p_yz) <<< 1;
      cosr <= OneQ28 - ((36'(p_xx) + 36'(p_yy)) <<< 1);
      sinp <= (36'(p_wy) - 36'(p_zx)) <<< 1;
      siny <= (36'(p_wz) + 36'(p_xy)) <<< 1;
      cosy <= OneQ28 - ((36'(p_yy) + 36'(p_zz)) <<< 1);
      sq <= sinp_lo * sinp_lo;
      clamp3 <= (sinp >= OneQ28) || (sinp <= -OneQ28);
      sinp3 <= CordW'(sinp);
    end
  end
  assign sq_rem = clamp3 ? 57'd0 : 57'((60'd1 << 56) - sq);

  logic signed [CordW-1:0] ry [Dly], rx [Dly], yy [Dly], yx [Dly];
  logic signed [CordW-1:0] sinr2, cosr2, siny2, cosy2;
  always_ff @(posedge clk) begin
    if (en) begin
      sinr2 <= CordW'(sinr); cosr2 <= CordW'(cosr);
      siny2 <= CordW'(siny); cosy2 <= CordW'(cosy);
      ry[0] <= sinr2; rx[0] <= cosr2; yy[0] <= siny2; yx[0] <= cosy2;
      for (int k = 0; k < Dly - 1; k++) begin
        ry[k+1] <= ry[k]; rx[k+1] <= rx[k]; yy[k+1] <= yy[k]; yx[k+1] <= yx[k];
      end
    end
  end

  logic sv;
  logic [28:0] root;
  logic signed [CordW-1:0] ss;
  logic sc;
  q2e_isqrt u_sqrt (
    .clk, .rst, .en, .in_valid(v3), .in_v(sq_rem), .in_s(sinp3), .in_clamp(clamp3),
    .out_valid(sv), .out_root(root), .out_s(ss), .out_clamp(sc)
  );

  logic cv, cvr, cvy;
  logic signed [33:0] zp, zr, zy;
  logic [0:0] tp;
  logic [0:0] tr, ty;
  q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TagW(1)) u_pitch (
    .clk, .rst, .en, .in_valid(sv), .in_y(ss), .in_x(CordW'({1'b0, root})),
    .in_tag(sc), .out_valid(cv), .out_z(zp), .out_tag(tp)
  );
  q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TagW(1)) u_roll (
    .clk, .rst, .en, .in_valid(sv), .in_y(ry[Dly-1]), .in_x(rx[Dly-1]),
    .in_tag(sc), .out_valid(cvr), .out_z(zr), .out_tag(tr)
  );
  q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TagW(1)) u_yaw (
    .clk, .rst, .en, .in_valid(sv), .in_y(yy[Dly-1]), .in_x(yx[Dly-1]),
    .in_tag(sc), .out_valid(cvy), .out_z(zy), .out_tag(ty)
  );

  logic mv;
  logic signed [49:0] mr, mp, my;
  logic mc;
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0; fin_v <= 1'b0;
    end else if (en) begin
      mv <= cv & cvr & cvy; fin_v <= mv;
    end
    if (en) begin
      mr <= 50'(zr) * 50'sd51472 + 50'(HalfTurn);
      mp <= 50'(zp) * $signed({34'd0, RadScale}) + 50'(HalfTurn);
      my <= 50'(zy) * 50'sd51472 + 50'(HalfTurn);
      mc <= tp[0] & tr[0] & ty[0];
    end
  end

  logic signed [17:0] rr, rp, ry_;
  assign rr = 18'(mr >>> 32);
  assign rp = 18'(mp >>> 32);
  assign ry_ = 18'(my >>> 32);
  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle <= (rr > PiQ13) ? PiQ13 : (rr < -PiQ13) ? -PiQ13 : 16'(rr);
      yaw_angle <= (ry_ > PiQ13) ? PiQ13 : (ry_ < -PiQ13) ? -PiQ13 : 16'(ry_);
      if (mc) begin
        // clamped: angle is forced to a quarter turn with the sign of the sine
        pitch_angle <= mp[49] ? 15'(-HalfPiQ13) : 15'(HalfPiQ13);
      end else begin
        pitch_angle <= (rp > HalfPiQ13) ? 15'(HalfPiQ13) :
                       (rp < -HalfPiQ13) ? 15'(-HalfPiQ13) : 15'(rp);
      end
      pitch_clamped <= mc;
    end
  end
  assign out_valid = fin_v;
endmodule
`default_nettype wire
